FILE: sv/bir_pkg.sv
// package for the bicubic image resize block
// types, sizes and register indexes; no dependencies
package bir_pkg;

    localparam int MaxWidth  = 512;
    localparam int MaxHeight = 512;
    localparam int FracBits  = 16;
    localparam int XW        = $clog2(MaxWidth);
    localparam int YW        = $clog2(MaxHeight);
    localparam int AddrW     = XW + YW;
    localparam int SizeW     = 10;
    localparam int StepW     = 25;
    localparam int CfgW      = 25;
    localparam int IdxW      = 2;
    // signed working width for the cubic datapath
    localparam int AccW      = 40;
    // reciprocal of six for 32-bit magnitudes, product taken from bit 34 up
    localparam logic [31:0] Div6Mul = 32'hAAAA_AAAB;

    typedef enum logic [IdxW-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_XSTEP  = 2'd2,
        REG_YSTEP  = 2'd3
    } reg_idx_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_COORD  = 6'b000010,
        ST_READ   = 6'b000100,
        ST_HPASS  = 6'b001000,
        ST_VPASS  = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    typedef logic signed [AccW-1:0] acc_t;

endpackage

FILE: sv/bicubic_image_resize.sv
// bicubic image resize: frame store plus sequential 4x4 cubic filter
// depends on bir_pkg
//
// usage: pulse start with command=0 to load a source pixel (one cycle, no
// result) or command=1 to compute target pixel (col,row). busy is high while
// a compute item is in progress; start is ignored while busy.
// config: cfg_we/cfg_index/cfg_data write the size and step registers; the user
// must write them only while idle, which the block does not enforce; no read-back.
// a compute item reads the sixteen neighbors from the single-port frame store,
// one per cycle, then runs fifteen cubics (four rows then the column, for
// three channels) on one shared multiplier. each cubic runs, in order, the
// coefficients, three multiply steps, the divide by six and the final add.
// busy drops as done rises, so the next item can be accepted while done is
// high. loads can follow back to back.
// the result appears on out_col/out_row/red_out/green_out/blue_out for one
// cycle with done high; the receiver cannot stall.
// reset clears control state and restores the register defaults; the frame
// store is undefined until written.
module bicubic_image_resize (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cfg_we,
    input  logic [bir_pkg::IdxW-1:0]    cfg_index,
    input  logic [bir_pkg::CfgW-1:0]    cfg_data,
    input  logic                        command,
    input  logic [8:0]                  col,
    input  logic [8:0]                  row,
    input  logic [7:0]                  red_in,
    input  logic [7:0]                  green_in,
    input  logic [7:0]                  blue_in,
    output logic                        done,
    output logic [8:0]                  out_col,
    output logic [8:0]                  out_row,
    output logic [7:0]                  red_out,
    output logic [7:0]                  green_out,
    output logic [7:0]                  blue_out
);
    import bir_pkg::*;

    // configuration registers
    logic [SizeW-1:0] width_reg, height_reg;
    logic [StepW-1:0] xstep_reg, ystep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SizeW'(512);
            height_reg <= SizeW'(512);
            xstep_reg  <= StepW'(65536);
            ystep_reg  <= StepW'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[SizeW-1:0];
                REG_HEIGHT: height_reg <= cfg_data[SizeW-1:0];
                REG_XSTEP:  xstep_reg  <= cfg_data[StepW-1:0];
                REG_YSTEP:  ystep_reg  <= cfg_data[StepW-1:0];
                default:    ;
            endcase
        end
    end

    // effective sizes: zero acts as one, above the store acts as the store
    logic [SizeW-1:0] w_eff, h_eff;
    always_comb
    begin
        w_eff = width_reg;
        if (width_reg == '0)
            w_eff = SizeW'(1);
        else if (width_reg > SizeW'(MaxWidth))
            w_eff = SizeW'(MaxWidth);
        h_eff = height_reg;
        if (height_reg == '0)
            h_eff = SizeW'(1);
        else if (height_reg > SizeW'(MaxHeight))
            h_eff = SizeW'(MaxHeight);
    end

    state_t state_reg, state_next;

    logic accept;
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // frame store, single port, registered read
    logic [23:0]      mem [0:(1<<AddrW)-1];
    logic [AddrW-1:0] mem_addr;
    logic             mem_we;
    logic [23:0]      mem_q;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= {red_in, green_in, blue_in};
        mem_q <= mem[mem_addr];
    end

    // item registers
    logic [8:0]  tcol_reg, trow_reg;
    logic [33:0] px_reg, py_reg;
    logic [XW-1:0] xs_reg [0:3];
    logic [YW-1:0] ys_reg [0:3];
    logic [4:0]  rd_cnt_reg;        // read counter, one extra for latency
    logic [23:0] nb_reg [0:15];     // neighborhood, row-major

    // cubic sequencer
    logic [1:0]  chan_reg;          // 0 red, 1 green, 2 blue
    logic [2:0]  pass_reg;          // rows 0..3, then 4 = column
    logic [1:0]  step_reg;          // multiply steps 0..2, 3 = divide and add
    logic        ph_reg;            // 0 coefficients or final add, 1 arithmetic
    acc_t        h_reg, a1_reg, a2_reg, s1_reg;
    acc_t        prod_reg;          // h divided by six
    acc_t        colv_reg [0:3];
    logic [7:0]  res_reg [0:2];

    // coordinate clamp on integer part
    function automatic logic [SizeW-1:0] clampc(input logic signed [18:0] v,
                                               input logic [SizeW-1:0] n);
        logic [SizeW-1:0] r;
        begin
            if (v < 0)
                r = '0;
            else if (v > $signed({9'd0, n}) - 19'sd1)
                r = n - SizeW'(1);
            else
                r = v[SizeW-1:0];
            clampc = r;
        end
    endfunction

    // sample fetch for the current channel
    function automatic acc_t sample(input logic [23:0] e, input logic [1:0] c);
        logic [7:0] b;
        begin
            case (c)
                2'd0:    b = e[23:16];
                2'd1:    b = e[15:8];
                default: b = e[7:0];
            endcase
            sample = acc_t'({b, {FracBits{1'b0}}});
        end
    endfunction

    // floor shift and round-half-away div by six
    function automatic acc_t fl(input logic signed [49:0] v);
        fl = acc_t'(v >>> FracBits);
    endfunction

    // magnitude stays below 2^31, so a 32-bit reciprocal multiply is exact
    function automatic acc_t div6r(input acc_t v);
        logic [31:0] m;
        logic [63:0] p;
        acc_t        q;
        begin
            m = (v < 0) ? 32'(-v) : 32'(v);
            p = 64'(m + 32'd3) * 64'(Div6Mul);
            q = acc_t'({10'd0, p[63:34]});
            div6r = (v < 0) ? -q : q;
        end
    endfunction

    // final rounding and clamp to 0..255
    function automatic logic [7:0] round8(input acc_t v);
        acc_t m;
        acc_t q;
        begin
            m = (v < 0) ? -v : v;
            q = (m + acc_t'(1 << (FracBits - 1))) >>> FracBits;
            if (v < 0 || q == 0)
                round8 = 8'd0;
            else if (q > 255)
                round8 = 8'd255;
            else
                round8 = q[7:0];
        end
    endfunction

    // operands of the current cubic
    acc_t s0, s1, s2, s3, d0, d2, d3;
    logic [FracBits-1:0] t_cur;
    always_comb
    begin
        if (pass_reg == 3'd4)
        begin
            s0 = colv_reg[0];
            s1 = colv_reg[1];
            s2 = colv_reg[2];
            s3 = colv_reg[3];
            t_cur = py_reg[15:0];
        end
        else
        begin
            s0 = sample(nb_reg[{pass_reg[1:0], 2'd0}], chan_reg);
            s1 = sample(nb_reg[{pass_reg[1:0], 2'd1}], chan_reg);
            s2 = sample(nb_reg[{pass_reg[1:0], 2'd2}], chan_reg);
            s3 = sample(nb_reg[{pass_reg[1:0], 2'd3}], chan_reg);
            t_cur = px_reg[15:0];
        end
        d0 = s0 - s1;
        d2 = s2 - s1;
        d3 = s3 - s1;
    end

    // shared multiplier: h times t, then floor shift
    logic signed [49:0] mul_full;
    assign mul_full = $signed(h_reg[32:0]) * $signed({1'b0, t_cur});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && command)
                    state_next = ST_COORD;
            ST_COORD:
                state_next = ST_READ;
            ST_READ:
                if (rd_cnt_reg == 5'd16)
                    state_next = ST_HPASS;
            ST_HPASS:
                if (!ph_reg && step_reg == 2'd3 && pass_reg == 3'd4 &&
                    chan_reg == 2'd2)
                    state_next = ST_OUT;
            ST_VPASS:
                state_next = ST_HPASS;
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // store address: load address, or the neighbor being read
    always_comb
    begin
        mem_we   = accept && !command;
        mem_addr = {row, col};
        if (state_reg == ST_READ)
            mem_addr = {ys_reg[rd_cnt_reg[3:2]], xs_reg[rd_cnt_reg[1:0]]};
    end

    // datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg <= '0;
            chan_reg   <= '0;
            pass_reg   <= '0;
            step_reg   <= '0;
            ph_reg     <= 1'b0;
            done       <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && command)
                    begin
                        tcol_reg <= col;
                        trow_reg <= row;
                        px_reg   <= 34'(col) * 34'(xstep_reg);
                        py_reg   <= 34'(row) * 34'(ystep_reg);
                    end
                end
                ST_COORD:
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        xs_reg[k] <= XW'(clampc($signed(19'(px_reg[33:16])) +
                                     19'(k - 1), w_eff));
                        ys_reg[k] <= YW'(clampc($signed(19'(py_reg[33:16])) +
                                     19'(k - 1), h_eff));
                    end
                    rd_cnt_reg <= '0;
                end
                ST_READ:
                begin
                    rd_cnt_reg <= (rd_cnt_reg == 5'd16) ? 5'd0 : rd_cnt_reg + 5'd1;
                    if (rd_cnt_reg != 5'd0)
                        nb_reg[rd_cnt_reg[3:0] - 4'd1] <= mem_q;
                    // first row coefficients are loaded in the first filter cycle
                    chan_reg <= '0;
                    pass_reg <= '0;
                    step_reg <= '0;
                    ph_reg   <= 1'b0;
                end
                ST_HPASS:
                begin
                    if (!ph_reg)
                    begin
                        if (step_reg == 2'd0)
                        begin
                            // load coefficients, h = A3
                            a1_reg <= -(d0 <<< 1) + (d2 <<< 2) + (d2 <<< 1) - d3;
                            a2_reg <= (d0 <<< 1) + d0 + (d2 <<< 1) + d2;
                            h_reg  <= -d0 - (d2 <<< 1) - d2 + d3;
                            s1_reg <= s1;
                            ph_reg <= 1'b1;
                        end
                        else
                        begin
                            // add the center sample and store the pass result
                            step_reg <= 2'd0;
                            if (pass_reg == 3'd4)
                            begin
                                res_reg[chan_reg] <= round8(s1_reg + prod_reg);
                                pass_reg <= '0;
                                chan_reg <= chan_reg + 2'd1;
                            end
                            else
                            begin
                                colv_reg[pass_reg[1:0]] <= s1_reg + prod_reg;
                                pass_reg <= pass_reg + 3'd1;
                            end
                        end
                    end
                    else
                    begin
                        case (step_reg)
                            2'd0:    h_reg <= fl(mul_full) + a2_reg;
                            2'd1:    h_reg <= fl(mul_full) + a1_reg;
                            2'd2:    h_reg <= fl(mul_full);
                            default: prod_reg <= div6r(h_reg);
                        endcase
                        if (step_reg == 2'd3)
                            ph_reg <= 1'b0;
                        else
                            step_reg <= step_reg + 2'd1;
                    end
                end
                ST_OUT:
                begin
                    done <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign out_col   = tcol_reg;
    assign out_row   = trow_reg;
    assign red_out   = res_reg[0];
    assign green_out = res_reg[1];
    assign blue_out  = res_reg[2];

`ifndef SYNTHESIS
    // a result strobe follows only a compute item
    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_OUT))
        else $error("done without output state");
    // busy covers the whole compute item
    a_busy_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> busy)
        else $error("read while not busy");
    // no store write during a compute item
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !mem_we)
        else $error("store write while busy");
    // read counter stays in range
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= 5'd16)
        else $error("read counter overflow");
`endif

endmodule

FILE: test/bicubic_image_resize_tb.sv
// testbench for bicubic_image_resize: random load and compute items checked
// against a bit-exact cubic predictor; depends on bir_pkg and the block's rtl
`timescale 1ns / 100ps

module bicubic_image_resize_tb;
    import bir_pkg::*;

    typedef struct packed {
        logic       command;
        logic [8:0] col;
        logic [8:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } px_item_t;

    typedef struct packed {
        logic [8:0] col;
        logic [8:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } px_result_t;

    localparam int SettleCycles = 200;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             cfg_we = 1'b0;
    logic [IdxW-1:0]  cfg_index = '0;
    logic [CfgW-1:0]  cfg_data = '0;
    logic             command = 1'b0;
    logic [8:0]       col = '0;
    logic [8:0]       row = '0;
    logic [7:0]       red_in = '0;
    logic [7:0]       green_in = '0;
    logic [7:0]       blue_in = '0;
    logic             done;
    logic [8:0]       out_col;
    logic [8:0]       out_row;
    logic [7:0]       red_out;
    logic [7:0]       green_out;
    logic [7:0]       blue_out;

    // predictor state: image copy and register shadows
    logic [23:0]      image_mem [0:MaxWidth*MaxHeight-1];
    logic [SizeW-1:0] width_reg = 10'd512;
    logic [SizeW-1:0] height_reg = 10'd512;
    logic [StepW-1:0] xstep_reg = 25'd65536;
    logic [StepW-1:0] ystep_reg = 25'd65536;

    // entries the stimulus has written, so no compute reads an unwritten one
    bit               loaded [0:MaxWidth*MaxHeight-1];

    px_item_t         pending_items [$];
    px_result_t       expected_pixels [$];
    px_item_t         cur_item;
    int               gap_left = 0;
    bit               no_gaps = 0;
    int               error_count = 0;
    int               items_queued = 0;
    int               pixels_checked = 0;
    int               phase_count = 0;

    bicubic_image_resize u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .command   (command),
        .col       (col),
        .row       (row),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .done      (done),
        .out_col   (out_col),
        .out_row   (out_row),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    always #10 clk = ~clk;

    // floor of v / 2^16
    function automatic longint floor_frac(longint v);
        if (v >= 0)
            return v >>> FracBits;
        return -((-v + 65535) >>> FracBits);
    endfunction

    function automatic longint div6_half_away(longint v);
        if (v >= 0)
            return (v + 3) / 6;
        return -((-v + 3) / 6);
    endfunction

    // one cubic pass, samples and result in Q.16
    function automatic longint cubic_pass(longint s0, longint s1, longint s2, longint s3,
                                          longint t);
        longint d0, d2, d3, a1, a2, a3, h;
        d0 = s0 - s1;
        d2 = s2 - s1;
        d3 = s3 - s1;
        a1 = -2 * d0 + 6 * d2 - d3;
        a2 = 3 * d0 + 3 * d2;
        a3 = -d0 - 3 * d2 + d3;
        h = floor_frac(a3 * t) + a2;
        h = floor_frac(h * t) + a1;
        h = floor_frac(h * t);
        return s1 + div6_half_away(h);
    endfunction

    function automatic longint eff_size(longint r, longint lim);
        if (r == 0)
            return 1;
        if (r > lim)
            return lim;
        return r;
    endfunction

    function automatic longint clamp_to(longint v, longint n);
        if (v < 0)
            return 0;
        if (v > n - 1)
            return n - 1;
        return v;
    endfunction

    // interpolated pixel for a target coordinate
    function automatic px_result_t interp_pixel(logic [8:0] tc, logic [8:0] tr);
        px_result_t res;
        longint w, h, px, py, tx, ty, v, q;
        longint xs [4];
        longint ys [4];
        longint s [4];
        longint rowv [4];
        logic [23:0] e;
        logic [7:0] chan [3];
        w = eff_size(longint'(width_reg), MaxWidth);
        h = eff_size(longint'(height_reg), MaxHeight);
        px = longint'(tc) * longint'(xstep_reg);
        py = longint'(tr) * longint'(ystep_reg);
        tx = px & 65535;
        ty = py & 65535;
        for (int k = 0; k < 4; k++)
        begin
            xs[k] = clamp_to((px >>> 16) - 1 + k, w);
            ys[k] = clamp_to((py >>> 16) - 1 + k, h);
        end
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    e = image_mem[ys[r] * MaxWidth + xs[k]];
                    s[k] = longint'((e >> (16 - 8 * c)) & 24'hff) <<< FracBits;
                end
                rowv[r] = cubic_pass(s[0], s[1], s[2], s[3], tx);
            end
            v = cubic_pass(rowv[0], rowv[1], rowv[2], rowv[3], ty);
            q = ((v < 0 ? -v : v) + 32768) >>> FracBits;
            if (v < 0)
                q = -q;
            if (q < 0)
                q = 0;
            if (q > 255)
                q = 255;
            chan[c] = q[7:0];
        end
        res.col = tc;
        res.row = tr;
        res.red = chan[0];
        res.green = chan[1];
        res.blue = chan[2];
        return res;
    endfunction

    // all sixteen neighbors of a target pixel were written
    function automatic bit neighbors_loaded(logic [8:0] tc, logic [8:0] tr);
        longint w, h, xi, yi;
        w = eff_size(longint'(width_reg), MaxWidth);
        h = eff_size(longint'(height_reg), MaxHeight);
        xi = (longint'(tc) * longint'(xstep_reg)) >>> 16;
        yi = (longint'(tr) * longint'(ystep_reg)) >>> 16;
        for (int r = 0; r < 4; r++)
            for (int k = 0; k < 4; k++)
                if (!loaded[clamp_to(yi - 1 + r, h) * MaxWidth + clamp_to(xi - 1 + k, w)])
                    return 0;
        return 1;
    endfunction

    task automatic queue_load(int c, int r, logic [23:0] rgb);
        px_item_t it;
        it = {1'b0, 9'(c), 9'(r), rgb};
        loaded[r * MaxWidth + c] = 1;
        pending_items = {pending_items, it};
        items_queued++;
    endtask

    task automatic queue_compute(int c, int r);
        px_item_t it;
        if (neighbors_loaded(9'(c), 9'(r)))
        begin
            it = {1'b1, 9'(c), 9'(r), 24'($urandom)};
            pending_items = {pending_items, it};
            items_queued++;
        end
    endtask

    // wait until every item is taken and every pixel has come back
    task automatic drain;
        while (pending_items.size() != 0 || start || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CfgW-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH:  width_reg = data[SizeW-1:0];
            REG_HEIGHT: height_reg = data[SizeW-1:0];
            REG_XSTEP:  xstep_reg = data[StepW-1:0];
            REG_YSTEP:  ystep_reg = data[StepW-1:0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // driver: hold start until taken, random gaps between items
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                if (cur_item.command == 1'b0)
                    image_mem[cur_item.row * MaxWidth + cur_item.col] =
                        {cur_item.red, cur_item.green, cur_item.blue};
                else
                    expected_pixels = {expected_pixels,
                                       interp_pixel(cur_item.col, cur_item.row)};
            end
            if (start && busy)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                cur_item = pending_items.pop_front();
                command <= cur_item.command;
                col <= cur_item.col;
                row <= cur_item.row;
                red_in <= cur_item.red;
                green_in <= cur_item.green;
                blue_in <= cur_item.blue;
                start <= 1'b1;
                if (!no_gaps && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 16);
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: every done pulse against the oldest expected pixel
    always @(posedge clk)
    begin
        px_result_t want;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected pixel, col", int'(out_col), -1);
            else
            begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (out_col !== want.col)
                    report_mismatch("out_col", int'(out_col), int'(want.col));
                if (out_row !== want.row)
                    report_mismatch("out_row", int'(out_row), int'(want.row));
                if (red_out !== want.red)
                    report_mismatch("red_out", int'(red_out), int'(want.red));
                if (green_out !== want.green)
                    report_mismatch("green_out", int'(green_out), int'(want.green));
                if (blue_out !== want.blue)
                    report_mismatch("blue_out", int'(blue_out), int'(want.blue));
            end
        end
    end

    // stimulus, phase by phase with register writes in between
    initial
    begin
        int w, h, tw, th, n;
        logic [CfgW-1:0] wv, hv, xv, yv;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers: checkerboard of extremes, corner load
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                queue_load(c, r, ((r + c) % 2) ? 24'hffffff : 24'h000000);
        queue_load(511, 511, 24'hffffff);
        queue_compute(0, 0);
        queue_compute(1, 1);
        queue_compute(0, 1);
        queue_compute(1, 0);
        drain();
        phase_count++;

        // zero sizes and zero steps: every read lands on the origin
        write_reg(REG_WIDTH, '0);
        write_reg(REG_HEIGHT, '0);
        write_reg(REG_XSTEP, '0);
        write_reg(REG_YSTEP, '0);
        queue_compute(511, 511);
        queue_compute(0, 0);
        queue_compute(511, 0);
        queue_compute(0, 511);
        drain();
        phase_count++;

        // sizes above the store and the largest steps: both image edges
        write_reg(REG_WIDTH, 25'h3ff);
        write_reg(REG_HEIGHT, 25'h3ff);
        write_reg(REG_XSTEP, 25'h1ffffff);
        write_reg(REG_YSTEP, 25'h1ffffff);
        for (int a = 0; a < 6; a++)
            for (int b = 0; b < 6; b++)
                queue_load(a < 3 ? a : 506 + a, b < 3 ? b : 506 + b, 24'($urandom));
        for (int k = 0; k < 4; k++)
            queue_compute(k % 2, k / 2);
        drain();
        phase_count++;

        // random phases: small image loaded whole, then mixed traffic
        while (items_queued < 650)
        begin
            if (items_queued > 560)
                no_gaps = 1;
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 10);
            wv = CfgW'(w);
            hv = CfgW'(h);
            if ($urandom_range(0, 7) == 0)
                wv = 0;
            if ($urandom_range(0, 7) == 0)
                hv = 0;
            if ($urandom_range(0, 5) == 0)
                wv[CfgW-1:SizeW] = (CfgW-SizeW)'($urandom);
            if ($urandom_range(0, 5) == 0)
                hv[CfgW-1:SizeW] = (CfgW-SizeW)'($urandom);
            tw = $urandom_range(1, 24);
            th = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0:       begin xv = '0; yv = 25'($urandom); end
                1:       begin xv = 25'h1ffffff; yv = 25'(($urandom_range(1, 10) << 16) / th); end
                2, 3:    begin xv = 25'($urandom); yv = 25'($urandom); end
                default: begin xv = 25'((w << 16) / tw); yv = 25'((h << 16) / th); end
            endcase
            write_reg(REG_WIDTH, wv);
            write_reg(REG_HEIGHT, hv);
            write_reg(REG_XSTEP, xv);
            write_reg(REG_YSTEP, yv);
            w = int'(eff_size(longint'(width_reg), MaxWidth));
            h = int'(eff_size(longint'(height_reg), MaxHeight));
            for (int r = 0; r < h; r++)
                for (int c = 0; c < w; c++)
                    queue_load(c, r, 24'($urandom));
            n = int'($urandom_range(30, 60));
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0:       queue_load($urandom_range(0, 511), $urandom_range(0, 511),
                                        24'($urandom));
                    1, 2:    queue_load($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                                        24'($urandom));
                    3:       queue_compute($urandom_range(0, 511), $urandom_range(0, 511));
                    default: queue_compute($urandom_range(0, tw - 1), $urandom_range(0, th - 1));
                endcase
            end
            drain();
            phase_count++;
        end

        $display("ran %0d items over %0d register settings, %0d pixels checked",
                 items_queued, phase_count, pixels_checked);
        if (error_count == 0)
            $display("bicubic_image_resize regression: pass");
        else
            $display("bicubic_image_resize regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #40ms;
        $display("bicubic_image_resize regression: fail");
        $finish;
    end

endmodule
